### hw/rtl/dmd_pkg.sv
// shared types, constants and month length function for the date subtractor
package dmd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   DECEMBER_DAYS   = 5'd31;
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE      = 14'd400;
    localparam logic [YEAR_W-1:0]  CENTURY_1       = 14'd100;
    localparam logic [YEAR_W-1:0]  CENTURY_2       = 14'd200;
    localparam logic [YEAR_W-1:0]  CENTURY_3       = 14'd300;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DATE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_WALK   = 3'b100
    } state_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (month) inside
                4'd2:
                begin
                    len = leap ? 5'd29 : 5'd28;
                end
                4'd4, 4'd6, 4'd9, 4'd11:
                begin
                    len = 5'd30;
                end
                default:
                begin
                    len = 5'd31;
                end
            endcase
            return len;
        end
    endfunction

endpackage

### hw/rtl/dmd_sub.sv
// shared subtract and compare unit of the date subtractor
module dmd_sub (
    input  logic [dmd_pkg::COUNT_W-1:0] a,
    input  logic [dmd_pkg::COUNT_W-1:0] b,
    output logic [dmd_pkg::COUNT_W-1:0] diff,
    output logic                        borrow
);

    logic [dmd_pkg::COUNT_W:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[dmd_pkg::COUNT_W-1:0];
    assign borrow = wide[dmd_pkg::COUNT_W];

endmodule

### hw/rtl/date_minus_days.sv
// date subtractor top level: sequencer, date registers and result beat
// A start beat is taken when start is high and busy is low. A bad start date
// gives its result in the cycle after acceptance. Otherwise the year is first
// reduced modulo 400 by repeated subtraction. Then the walk steps back one
// month at a time, takes one more step when days are left over inside a
// month, and one final step; both phases share one 16-bit subtractor. The
// result beat shows on done the cycle after that and lasts exactly one cycle;
// it cannot be held off, and a new start may be taken in that same cycle.
module date_minus_days (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [13:0] start_year,
    input  logic [6:0]  start_month,
    input  logic [6:0]  start_day,
    input  logic [15:0] days_back,
    output logic        busy,
    output logic        done,
    output logic [13:0] result_year,
    output logic [3:0]  result_month,
    output logic [4:0]  result_day,
    output logic [1:0]  status
);

    dmd_pkg::state_t state_reg, state_next;

    logic [dmd_pkg::YEAR_W-1:0]   year_reg, year_next;
    logic [dmd_pkg::MONTH_W-1:0]  month_reg, month_next;
    logic [dmd_pkg::DAY_W-1:0]    day_reg, day_next;
    logic [dmd_pkg::COUNT_W-1:0]  left_reg, left_next;
    logic [dmd_pkg::YEAR_W-1:0]   mod_reg, mod_next;

    logic                         done_reg, done_next;
    logic [dmd_pkg::YEAR_W-1:0]   res_year_reg, res_year_next;
    logic [dmd_pkg::MONTH_W-1:0]  res_month_reg, res_month_next;
    logic [dmd_pkg::DAY_W-1:0]    res_day_reg, res_day_next;
    logic [dmd_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic [dmd_pkg::COUNT_W-1:0]  sub_a, sub_b, sub_diff;
    logic                         sub_borrow;
    logic                         accept;
    logic                         date_ok;
    logic                         leap;
    logic [dmd_pkg::MONTH_W-1:0]  month_dec;

    dmd_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign accept  = start && !busy;
    assign date_ok = (start_year != 14'd0) && (start_month != 7'd0) &&
                     (start_month <= 7'd12) && (start_day != 7'd0) &&
                     (start_day <= 7'd31);

    assign leap = (year_reg[1:0] == 2'b00) &&
                  !((mod_reg == dmd_pkg::CENTURY_1) || (mod_reg == dmd_pkg::CENTURY_2) ||
                    (mod_reg == dmd_pkg::CENTURY_3));
    assign month_dec = month_reg - 4'd1;

    // shared unit operands
    always_comb
    begin
        if (state_reg == dmd_pkg::ST_REDUCE)
        begin
            sub_a = {2'b00, mod_reg};
            sub_b = {2'b00, dmd_pkg::LEAP_CYCLE};
        end
        else
        begin
            sub_a = left_reg;
            sub_b = {11'd0, day_reg};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        left_next       = left_reg;
        mod_next        = mod_reg;
        done_next       = 1'b0;
        res_year_next   = res_year_reg;
        res_month_next  = res_month_reg;
        res_day_next    = res_day_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            dmd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    year_next  = start_year;
                    month_next = start_month[3:0];
                    day_next   = start_day[4:0];
                    left_next  = days_back;
                    mod_next   = start_year;
                    if (date_ok)
                    begin
                        state_next = dmd_pkg::ST_REDUCE;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        res_year_next   = '0;
                        res_month_next  = '0;
                        res_day_next    = '0;
                        res_status_next = dmd_pkg::STATUS_BAD_DATE;
                    end
                end
            end
            dmd_pkg::ST_REDUCE:
            begin
                if (!sub_borrow)
                begin
                    mod_next = sub_diff[dmd_pkg::YEAR_W-1:0];
                end
                else
                begin
                    state_next = dmd_pkg::ST_WALK;
                end
            end
            dmd_pkg::ST_WALK:
            begin
                if (left_reg == '0)
                begin
                    state_next      = dmd_pkg::ST_IDLE;
                    done_next       = 1'b1;
                    res_year_next   = year_reg;
                    res_month_next  = month_reg;
                    res_day_next    = day_reg;
                    res_status_next = dmd_pkg::STATUS_OK;
                end
                else if (!sub_borrow)
                begin
                    // whole month used up
                    left_next = sub_diff;
                    if (month_reg > 4'd1)
                    begin
                        month_next = month_dec;
                        day_next   = dmd_pkg::month_len(month_dec, leap);
                    end
                    else if (year_reg <= 14'd1)
                    begin
                        state_next      = dmd_pkg::ST_IDLE;
                        done_next       = 1'b1;
                        res_year_next   = '0;
                        res_month_next  = '0;
                        res_day_next    = '0;
                        res_status_next = dmd_pkg::STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        year_next  = year_reg - 14'd1;
                        month_next = dmd_pkg::MONTHS_PER_YEAR;
                        day_next   = dmd_pkg::DECEMBER_DAYS;
                        mod_next   = (mod_reg == '0) ? (dmd_pkg::LEAP_CYCLE - 14'd1)
                                                     : (mod_reg - 14'd1);
                    end
                end
                else
                begin
                    // remainder fits inside the current month
                    day_next  = day_reg - left_reg[dmd_pkg::DAY_W-1:0];
                    left_next = '0;
                end
            end
            default:
            begin
                state_next = dmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmd_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg       <= year_next;
        month_reg      <= month_next;
        day_reg        <= day_next;
        left_reg       <= left_next;
        mod_reg        <= mod_next;
        res_year_reg   <= res_year_next;
        res_month_reg  <= res_month_next;
        res_day_reg    <= res_day_next;
        res_status_reg <= res_status_next;
    end

    assign busy         = (state_reg != dmd_pkg::ST_IDLE);
    assign done         = done_reg;
    assign result_year  = res_year_reg;
    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign status       = res_status_reg;

    // a good result is a real date
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dmd_pkg::STATUS_OK) |->
            (result_month >= 4'd1 && result_month <= 4'd12 &&
             result_day >= 5'd1 && result_year != 14'd0))
        else $error("ok result beat carries an impossible date");

    // a failed result carries zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != dmd_pkg::STATUS_OK) |->
            (result_year == '0 && result_month == '0 && result_day == '0))
        else $error("failed result beat has non-zero date fields");

    // an accepted beat either starts work or finishes at once
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted beat was dropped");

    // no result beat while the sequencer was idle with nothing accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(busy) && !$past(accept)) |-> !done)
        else $error("result beat without work");

endmodule
